@@ sv/psdr_pkg.sv @@
// ----------------------------------------------------------------------------
// psdr_pkg
// Shared types and constants for the pairwise squared distance row block.
// ----------------------------------------------------------------------------
package psdr_pkg;

    localparam int NUM_COORDS = 4;
    localparam int COORD_BITS = 16;
    localparam int SQ_BITS    = 32;   // (2^16 - 1)^2 fits in 32 bits
    localparam int DIST_BITS  = 34;
    localparam int IDX_BITS   = 6;
    localparam int DIMS_BITS  = 3;

    localparam logic [DIMS_BITS-1:0] DIMS_RESET = 3'd2;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [SQ_BITS-1:0]           t_sq;
    typedef logic [DIST_BITS-1:0]         t_dist;

    typedef struct packed {
        logic [NUM_COORDS-1:0] lane_on;     // coordinate takes part
        logic                  force_zero;  // diagonal or overflow entry
    } t_merge_ctl;

endpackage

@@ sv/pairwise_squared_distance_rows.sv @@
// ----------------------------------------------------------------------------
// pairwise_squared_distance_rows
// Stores point vectors and emits one lower-triangle row of squared distances
// per vector.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries cmd and four Q4.12 coordinates.
//   cmd clear empties the set before the vector is appended. The vector is
//   written into the point RAM at the transfer and a row is emitted on the
//   output channel (o_valid / i_stall): one entry per earlier vector in
//   storage order, then a zero diagonal entry with last_of_row set. A vector
//   that finds the store full yields one overflow entry and is dropped.
//   One stored vector is read per cycle while the receiver does not stall,
//   and all coordinates are handled by parallel lanes. A new vector is not
//   taken until the previous row has passed the single RAM read port and
//   the three-stage read/square/sum pipeline up to the output register.
//   When the receiver stalls, the whole pipeline holds; the output register
//   keeps its entry, and a new vector may be taken while the last entry of
//   the previous row waits there.
//   Reset empties the set and sets dims_in_use to 2; RAM contents are kept.
//   dims_in_use is written through i_cfg_wr_en / i_cfg_wr_data; the user
//   must write it only while idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module pairwise_squared_distance_rows
    import psdr_pkg::*;
#(
    parameter int MAX_POINTS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [DIMS_BITS-1:0]  i_cfg_wr_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_cmd,
    input  t_coord                i_coord_0,
    input  t_coord                i_coord_1,
    input  t_coord                i_coord_2,
    input  t_coord                i_coord_3,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [IDX_BITS-1:0]   o_row_index,
    output logic [IDX_BITS-1:0]   o_col_index,
    output t_dist                 o_sq_distance,
    output logic                  o_last_of_row,
    output logic                  o_overflow
);

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int VEC_W = NUM_COORDS * COORD_BITS;

    // control
    logic [DIMS_BITS-1:0] r_dims;
    logic [CW-1:0]        r_count;
    logic                 r_busy;
    logic                 r_ovf;
    logic [CW-1:0]        r_row;
    logic [CW-1:0]        r_col;
    logic [VEC_W-1:0]     r_vec;

    // pipeline tags: stage 1 = RAM data, stage 2 = lane squares
    logic                 r_v1, r_last1, r_ovf1;
    logic [CW-1:0]        r_col1;
    logic                 r_v2, r_last2, r_ovf2;
    logic [CW-1:0]        r_col2;

    // output register
    logic                 r_out_v;
    logic [CW-1:0]        r_out_row;
    logic [CW-1:0]        r_out_col;
    t_dist                r_out_dist;
    logic                 r_out_last;
    logic                 r_out_ovf;

    logic                 adv;
    logic                 accept;
    logic [CW-1:0]        row_new;
    logic                 ovf_new;
    logic                 rd_issue;
    logic [VEC_W-1:0]     vec_in;
    logic [VEC_W-1:0]     rd_data;
    t_sq                  sq [NUM_COORDS];
    t_merge_ctl           merge_ctl;
    t_dist                merged_dist;
    logic [CW+IDX_BITS-1:0] row_ext;
    logic [CW+IDX_BITS-1:0] col_ext;

    assign adv     = !r_out_v || !i_stall;
    assign o_stall = r_busy || r_v1 || r_v2;
    assign accept  = i_valid && !o_stall;
    assign row_new = (i_cmd == CMD_CLEAR) ? '0 : r_count;
    assign ovf_new = (row_new >= CW'(MAX_POINTS));
    assign vec_in  = {i_coord_3, i_coord_2, i_coord_1, i_coord_0};
    assign rd_issue = r_busy && !r_ovf && (r_col != r_row);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims  <= DIMS_RESET;
            r_count <= '0;
            r_busy  <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_dims <= i_cfg_wr_data;
            end
            if (accept) begin
                r_busy <= 1'b1;
                if (!ovf_new) begin
                    r_count <= row_new + CW'(1);
                end else begin
                    r_count <= row_new;
                end
            end else if (adv && r_busy && !rd_issue) begin
                r_busy <= 1'b0;
            end
            if (adv) begin
                r_v1    <= r_busy;
                r_v2    <= r_v1;
                r_out_v <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_row <= row_new;
            r_col <= '0;
            r_ovf <= ovf_new;
            r_vec <= vec_in;
        end else if (adv && rd_issue) begin
            r_col <= r_col + CW'(1);
        end
        if (adv) begin
            r_col1     <= r_ovf ? '0 : r_col;
            r_last1    <= !rd_issue;
            r_ovf1     <= r_ovf;
            r_col2     <= r_col1;
            r_last2    <= r_last1;
            r_ovf2     <= r_ovf1;
            r_out_row  <= r_ovf2 ? '0 : r_row;
            r_out_col  <= r_col2;
            r_out_dist <= merged_dist;
            r_out_last <= r_last2;
            r_out_ovf  <= r_ovf2;
        end
    end

    psdr_ram #(
        .WIDTH (VEC_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (accept && !ovf_new),
        .i_wr_addr (row_new[AW-1:0]),
        .i_wr_data (vec_in),
        .i_rd_en   (adv),
        .i_rd_addr (r_col[AW-1:0]),
        .o_rd_data (rd_data)
    );

    for (genvar k = 0; k < NUM_COORDS; k++) begin : g_lane
        psdr_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (adv),
            .i_new    (r_vec[k*COORD_BITS +: COORD_BITS]),
            .i_stored (rd_data[k*COORD_BITS +: COORD_BITS]),
            .o_sq     (sq[k])
        );
        // dims_in_use above the lane count saturates naturally here
        assign merge_ctl.lane_on[k] = (r_dims > DIMS_BITS'(k));
    end

    assign merge_ctl.force_zero = r_last2 || r_ovf2;

    psdr_merge u_merge (
        .i_sq   (sq),
        .i_ctl  (merge_ctl),
        .o_dist (merged_dist)
    );

    assign row_ext = {{IDX_BITS{1'b0}}, r_out_row};
    assign col_ext = {{IDX_BITS{1'b0}}, r_out_col};

    assign o_valid       = r_out_v;
    assign o_row_index   = row_ext[IDX_BITS-1:0];
    assign o_col_index   = col_ext[IDX_BITS-1:0];
    assign o_sq_distance = r_out_dist;
    assign o_last_of_row = r_out_last;
    assign o_overflow    = r_out_ovf;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_POINTS))
        else $error("point count beyond capacity");

    a_ovf_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out_ovf |-> r_out_last && (r_out_dist == '0))
        else $error("overflow entry not a single zero entry");

    a_col_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !r_last2 |-> (r_col2 < r_row))
        else $error("off-diagonal column not below row");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && i_stall |=> r_out_v && $stable(r_out_dist) && $stable(r_out_col))
        else $error("output entry lost under stall");
`endif

endmodule

@@ sv/psdr_ram.sv @@
// ----------------------------------------------------------------------------
// psdr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psdr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/psdr_lane.sv @@
// ----------------------------------------------------------------------------
// psdr_lane
// One coordinate lane: difference of new and stored coordinate, squared,
// registered.
// ----------------------------------------------------------------------------
module psdr_lane
    import psdr_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_en,
    input  t_coord i_new,
    input  t_coord i_stored,
    output t_sq    o_sq
);

    logic signed [COORD_BITS:0]       diff;
    logic signed [2*COORD_BITS+1:0]   prod;
    t_sq                              r_sq;

    always_comb begin
        diff = {i_new[COORD_BITS-1], i_new} - {i_stored[COORD_BITS-1], i_stored};
        prod = diff * diff;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= prod[SQ_BITS-1:0];
        end
    end

    assign o_sq = r_sq;

endmodule

@@ sv/psdr_merge.sv @@
// ----------------------------------------------------------------------------
// psdr_merge
// Adds the squares of the active lanes into one distance; zero on force_zero.
// ----------------------------------------------------------------------------
module psdr_merge
    import psdr_pkg::*;
(
    input  t_sq        i_sq [NUM_COORDS],
    input  t_merge_ctl i_ctl,
    output t_dist      o_dist
);

    t_dist sum;

    always_comb begin
        sum = '0;
        for (int k = 0; k < NUM_COORDS; k++) begin
            if (i_ctl.lane_on[k]) begin
                sum = sum + DIST_BITS'(i_sq[k]);
            end
        end
        if (i_ctl.force_zero) begin
            sum = '0;
        end
    end

    assign o_dist = sum;

endmodule

@@ dv/psdr_row_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psdr_row_checker
// Watches both channels and the dims_in_use write port of the distance row
// block. Keeps its own copy of the point set and the register, works out each
// expected row when a vector transfers in, and compares every output transfer
// field by field against the oldest expected entry.
// ----------------------------------------------------------------------------
module psdr_row_checker
    import psdr_pkg::*;
#(
    parameter int MAX_POINTS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [DIMS_BITS-1:0] i_cfg_wr_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic                 i_cmd,
    input  t_coord               i_coord_0,
    input  t_coord               i_coord_1,
    input  t_coord               i_coord_2,
    input  t_coord               i_coord_3,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [IDX_BITS-1:0]  i_row_index,
    input  logic [IDX_BITS-1:0]  i_col_index,
    input  t_dist                i_sq_distance,
    input  logic                 i_last_of_row,
    input  logic                 i_overflow,
    output int                   o_error_count,
    output int                   o_pending
);

    typedef struct packed {
        logic [IDX_BITS-1:0] row;
        logic [IDX_BITS-1:0] col;
        t_dist               sq_dist;
        logic                last;
        logic                ovf;
    } t_dist_entry;

    t_coord               point_mem [MAX_POINTS][NUM_COORDS];
    int unsigned          stored_count = 0;
    logic [DIMS_BITS-1:0] dims_reg = DIMS_RESET;
    t_dist_entry          expected_rows [$];
    int                   error_count = 0;
    int                   pending = 0;

    assign o_error_count = error_count;
    assign o_pending     = pending;

    function automatic t_dist_entry make_entry(input int unsigned row, input int unsigned col,
                                               input t_dist sq_dist, input logic last,
                                               input logic ovf);
        t_dist_entry e;
        e.row     = row[IDX_BITS-1:0];
        e.col     = col[IDX_BITS-1:0];
        e.sq_dist = sq_dist;
        e.last    = last;
        e.ovf     = ovf;
        return e;
    endfunction

    task automatic flag(input string msg);
        error_count++;
        $error("%s", msg);
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) flag($sformatf("%s: expected %0d, got %0d", name, want, got));
    endtask

    task automatic predict_row();
        t_coord      vec [NUM_COORDS];
        int unsigned used;
        int unsigned row;
        longint      sum;
        longint      diff;
        vec[0] = i_coord_0;
        vec[1] = i_coord_1;
        vec[2] = i_coord_2;
        vec[3] = i_coord_3;
        if (i_cmd == CMD_CLEAR) stored_count = 0;
        if (stored_count >= MAX_POINTS) begin
            // store full: vector dropped, single overflow entry
            expected_rows.push_back(make_entry(0, 0, '0, 1'b1, 1'b1));
        end else begin
            used = (dims_reg > NUM_COORDS) ? NUM_COORDS : dims_reg;
            row  = stored_count;
            for (int j = 0; j < row; j++) begin
                sum = 0;
                for (int k = 0; k < used; k++) begin
                    diff = longint'(vec[k]) - longint'(point_mem[j][k]);
                    sum += diff * diff;
                end
                expected_rows.push_back(make_entry(row, j, t_dist'(sum), 1'b0, 1'b0));
            end
            expected_rows.push_back(make_entry(row, row, '0, 1'b1, 1'b0));
            for (int k = 0; k < NUM_COORDS; k++) point_mem[row][k] = vec[k];
            stored_count = row + 1;
        end
    endtask

    task automatic check_entry();
        t_dist_entry want;
        if (expected_rows.size() == 0) begin
            flag($sformatf("unexpected result: row_index %0d col_index %0d",
                           i_row_index, i_col_index));
        end else begin
            want = expected_rows.pop_front();
            check_field("row_index",   want.row,     i_row_index);
            check_field("col_index",   want.col,     i_col_index);
            check_field("sq_distance", want.sq_dist, i_sq_distance);
            check_field("last_of_row", want.last,    i_last_of_row);
            check_field("overflow",    want.ovf,     i_overflow);
        end
    endtask

    // outputs are retired before new input is predicted; a row never
    // reaches the output in the cycle its vector transfers in
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stored_count = 0;
            dims_reg     = DIMS_RESET;
            expected_rows.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_entry();
            if (i_cfg_wr_en) dims_reg = i_cfg_wr_data;
            if (i_in_valid && !i_in_stall) predict_row();
        end
        pending = expected_rows.size();
    end

endmodule

@@ dv/tb_pairwise_squared_distance_rows.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pairwise_squared_distance_rows
// Drives point vectors and dims_in_use writes into the distance row block,
// with random gaps on the input side and random stalls on the output side.
// A directed pass covers coordinate extremes, clear, unused coordinates and
// every dims_in_use corner; random passes run clear-then-append sequences,
// stray items and full-store overflow. The checker does all comparison.
// ----------------------------------------------------------------------------
module tb_pairwise_squared_distance_rows;
    import psdr_pkg::*;

    localparam int     MAX_POINTS = 64;
    localparam int     IDLE_GAP   = 16;   // covers the 3-stage pipeline with margin
    localparam int     END_GAP    = 32;
    localparam int     PHASE_LEN  = 110;
    localparam t_coord COORD_MAX  = 16'sh7FFF;
    localparam t_coord COORD_MIN  = 16'sh8000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [DIMS_BITS-1:0] i_cfg_wr_data;
    logic                 i_valid;
    logic                 o_stall;
    logic                 i_cmd;
    t_coord               i_coord_0;
    t_coord               i_coord_1;
    t_coord               i_coord_2;
    t_coord               i_coord_3;
    logic                 o_valid;
    logic                 i_stall;
    logic [IDX_BITS-1:0]  o_row_index;
    logic [IDX_BITS-1:0]  o_col_index;
    t_dist                o_sq_distance;
    logic                 o_last_of_row;
    logic                 o_overflow;

    int error_count;
    int pending;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int items_sent         = 0;

    pairwise_squared_distance_rows #(
        .MAX_POINTS (MAX_POINTS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_coord_0     (i_coord_0),
        .i_coord_1     (i_coord_1),
        .i_coord_2     (i_coord_2),
        .i_coord_3     (i_coord_3),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_row_index   (o_row_index),
        .o_col_index   (o_col_index),
        .o_sq_distance (o_sq_distance),
        .o_last_of_row (o_last_of_row),
        .o_overflow    (o_overflow)
    );

    psdr_row_checker #(
        .MAX_POINTS (MAX_POINTS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_cmd         (i_cmd),
        .i_coord_0     (i_coord_0),
        .i_coord_1     (i_coord_1),
        .i_coord_2     (i_coord_2),
        .i_coord_3     (i_coord_3),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_row_index   (o_row_index),
        .i_col_index   (o_col_index),
        .i_sq_distance (o_sq_distance),
        .i_last_of_row (o_last_of_row),
        .i_overflow    (o_overflow),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_stall = ($urandom_range(99) < receiver_stall_pct);
    end

    initial begin
        #2_000_000;
        $display("pairwise_squared_distance_rows test failed");
        $finish;
    end

    function automatic t_coord pick_coord();
        case ($urandom_range(3))
            0:       return $urandom_range(1) ? COORD_MAX : COORD_MIN;
            1:       return t_coord'($signed($urandom_range(16)) - 8);
            default: return t_coord'($urandom);
        endcase
    endfunction

    task automatic send_vector(input logic cmd, input t_coord c0, input t_coord c1,
                               input t_coord c2, input t_coord c3);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_cmd     = cmd;
        i_coord_0 = c0;
        i_coord_1 = c1;
        i_coord_2 = c2;
        i_coord_3 = c3;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic send_random(input logic cmd);
        send_vector(cmd, pick_coord(), pick_coord(), pick_coord(), pick_coord());
    endtask

    // hold the input side until every expected entry has come out
    task automatic wait_idle(input int extra);
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic write_dims(input logic [DIMS_BITS-1:0] value);
        wait_idle(IDLE_GAP);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = value;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input bit with_fill);
        int goal;
        sender_idle_pct    = send_pct;
        receiver_stall_pct = recv_pct;
        write_dims(DIMS_BITS'($urandom_range(7)));
        goal = items_sent + PHASE_LEN;
        if (with_fill) begin
            // fill the store, then push past capacity
            send_random(CMD_CLEAR);
            repeat (MAX_POINTS - 1) send_random(CMD_APPEND);
            repeat ($urandom_range(1, 3)) send_random(CMD_APPEND);
        end
        while (items_sent < goal) begin
            case ($urandom_range(9))
                0: write_dims(DIMS_BITS'($urandom_range(7)));
                1, 2: send_random(1'($urandom_range(1)));
                default: begin
                    send_random(CMD_CLEAR);
                    repeat ($urandom_range(10)) send_random(CMD_APPEND);
                end
            endcase
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_valid       = 1'b0;
        i_cmd         = CMD_APPEND;
        i_coord_0     = '0;
        i_coord_1     = '0;
        i_coord_2     = '0;
        i_coord_3     = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset dims: first alone, third differs from first only in unused lanes
        send_vector(CMD_APPEND, COORD_MAX, COORD_MIN, 16'sh1234, -16'sd1);
        send_vector(CMD_APPEND, COORD_MIN, COORD_MAX, '0, '0);
        send_vector(CMD_APPEND, COORD_MAX, COORD_MIN, 16'sh5555, 16'shAAAA);

        // full width, opposite corners give the largest distance
        write_dims(3'd4);
        send_vector(CMD_CLEAR, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_vector(CMD_APPEND, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        send_vector(CMD_APPEND, '0, '0, '0, '0);
        send_vector(CMD_APPEND, 16'sd1, -16'sd1, 16'sh5555, 16'shAAAA);

        // no coordinates in use: all distances zero
        write_dims(3'd0);
        send_random(CMD_CLEAR);
        send_random(CMD_APPEND);
        send_random(CMD_APPEND);

        // above the lane count saturates to four
        write_dims(3'd7);
        send_vector(CMD_CLEAR, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
        send_vector(CMD_APPEND, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
        send_random(CMD_APPEND);

        write_dims(3'd5);
        send_random(CMD_APPEND);
        send_random(CMD_APPEND);

        write_dims(3'd1);
        send_random(CMD_APPEND);
        send_vector(CMD_APPEND, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);

        write_dims(3'd3);
        send_random(CMD_CLEAR);
        send_random(CMD_APPEND);

        run_phase(36, 46, 1'b1);
        run_phase(46, 36, 1'b0);
        run_phase(0, 0, 1'b1);

        wait_idle(END_GAP);
        if (error_count == 0 && pending == 0) begin
            $display("pairwise_squared_distance_rows test passed");
        end else begin
            $display("pairwise_squared_distance_rows test failed");
        end
        $finish;
    end

endmodule

@@ pairwise_squared_distance_rows.f @@
sv/psdr_pkg.sv
sv/psdr_ram.sv
sv/psdr_lane.sv
sv/psdr_merge.sv
sv/pairwise_squared_distance_rows.sv
dv/psdr_row_checker.sv
dv/tb_pairwise_squared_distance_rows.sv
